>>> src/sgbs_pkg.sv
// Shared types, constants and helpers for the sky/ground background shader.
// No dependencies.
package sgbs_pkg;

   localparam int PIX_W          = 10;
   localparam int EYE_W          = 16;
   localparam int GRAY_W         = 8;
   localparam int CSR_IDX_W      = 2;
   localparam int DQ_W           = 17;   // magnitude of a normalized component, Q1.16
   localparam int SCALE_SHIFT_DEF = 9;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EYE_X = 2'd0,
      CSR_EYE_Y = 2'd1,
      CSR_EYE_Z = 2'd2
   } csr_idx_type;

   localparam logic signed [EYE_W-1:0] EYE_X_RST = 16'sd0;
   localparam logic signed [EYE_W-1:0] EYE_Y_RST = 16'sd256;
   localparam logic signed [EYE_W-1:0] EYE_Z_RST = -16'sd1024;

   // Parity of floor(n/d) saturated to 16 bits, from q = |n|/d, remainder flag and sign.
   function automatic logic sat_parity(input logic [DQ_W-1:0] q, input logic rem_nz,
                                       input logic neg, input logic ovf);
      logic big;
      logic par;
      if (!neg) begin
         big = ovf | q[DQ_W-1] | q[DQ_W-2];
         par = big ? 1'b1 : q[0];
      end else begin
         // ceiling beyond 32768 saturates to -32768, which is even
         big = ovf | q[DQ_W-1] | (q[DQ_W-2] & ((|q[DQ_W-3:0]) | rem_nz));
         par = big ? 1'b0 : (q[0] ^ rem_nz);
      end
      return par;
   endfunction

endpackage

>>> src/sgbs_ifs.sv
// Channel interfaces: pixel request, gray response, register write.
// Depends on sgbs_pkg.
interface sgbs_req_if;
   import sgbs_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [PIX_W-1:0] pixel_x;
   logic signed [PIX_W-1:0] pixel_y;
   modport source (output valid, pixel_x, pixel_y, input ready);
   modport sink   (input valid, pixel_x, pixel_y, output ready);
endinterface

interface sgbs_rsp_if;
   import sgbs_pkg::*;
   logic              valid;
   logic              ready;
   logic [GRAY_W-1:0] gray_level;
   logic              hit_ground;
   modport source (output valid, gray_level, hit_ground, input ready);
   modport sink   (input valid, gray_level, hit_ground, output ready);
endinterface

interface sgbs_csr_if;
   import sgbs_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [EYE_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> src/sky_ground_background_shader.sv
// One pixel per clock while the response side keeps up, fully pipelined. A pixel passes
// stage P, the bit-per-stage square root (ROOT_W is half the padded radicand width),
// the first bit-per-stage divider chain, stages M1 and M2, the second divider chain and
// the output register. The whole pipe advances whenever the output word is free or
// taken, so a new pixel is accepted every cycle the response side keeps up.
// Eye registers must be written while the pipe is empty; writes are always accepted.
// Depends on sgbs_pkg, sgbs_ifs, sgbs_sqrt_pipe, sgbs_div_pipe.
module sky_ground_background_shader #(
   parameter int SCALE_SHIFT = sgbs_pkg::SCALE_SHIFT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   sgbs_req_if.sink    req_ch,
   sgbs_rsp_if.source  rsp_ch,
   sgbs_csr_if.sink    csr_ch
);
   import sgbs_pkg::*;

   localparam int A_W    = (SCALE_SHIFT + 3 > 12) ? SCALE_SHIFT + 3 : 12;
   localparam int SUM_W  = (2 * SCALE_SHIFT + 4 > 23) ? 2 * SCALE_SHIFT + 4 : 23;
   localparam int RAD_W  = SUM_W + 32 + (SUM_W % 2);
   localparam int ROOT_W = RAD_W / 2;
   localparam int N_W    = A_W + 33;
   localparam int PROD_W = EYE_W + DQ_W + 1;
   localparam int NUM_W  = PROD_W + 1;
   localparam int DEN_W  = DQ_W + 8;
   localparam int ZSB_W  = 3 + GRAY_W;
   localparam logic [SUM_W-1:0] AZ_SQ  = SUM_W'(1) << (2 * SCALE_SHIFT + 2);
   localparam logic [A_W-1:0]   AZ_MAG = A_W'(1) << (SCALE_SHIFT + 1);

   // eye registers
   logic signed [EYE_W-1:0] eye_x_ff, eye_y_ff, eye_z_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eye_x_ff <= EYE_X_RST;
         eye_y_ff <= EYE_Y_RST;
         eye_z_ff <= EYE_Z_RST;
      end else if (csr_ch.valid) begin
         unique case (csr_idx_type'(csr_ch.index))
            CSR_EYE_X: eye_x_ff <= csr_ch.data;
            CSR_EYE_Y: eye_y_ff <= csr_ch.data;
            CSR_EYE_Z: eye_z_ff <= csr_ch.data;
            default: ;
         endcase
      end
   end

   logic adv;
   logic rsp_v_ff;
   assign adv          = !rsp_v_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // stage P: ray components and squared length
   logic signed [A_W-1:0]   px_ext, py_ext, ax_c, ay_c;
   logic signed [2*A_W-1:0] sqx, sqy;
   logic                    p_v_ff;
   logic signed [A_W-1:0]   ax_ff, ay_ff;
   logic [SUM_W-1:0]        sum_ff;

   assign px_ext = A_W'(req_ch.pixel_x);
   assign py_ext = A_W'(req_ch.pixel_y);
   assign ax_c   = (px_ext <<< 1) - A_W'(1);
   assign ay_c   = (py_ext <<< 1) - A_W'(1);
   assign sqx    = ax_c * ax_c;
   assign sqy    = ay_c * ay_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
      end else if (adv) begin
         p_v_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax_ff  <= ax_c;
         ay_ff  <= ay_c;
         sum_ff <= SUM_W'(sqx) + SUM_W'(sqy) + AZ_SQ;
      end
   end

   // length: r = floor(sqrt(sum * 2^32))
   logic              sq_v;
   logic [ROOT_W-1:0] sq_root;
   logic [2*A_W-1:0]  sq_sb;

   sgbs_sqrt_pipe #(.RAD_W(RAD_W), .SB_W(2 * A_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (p_v_ff),
      .in_rad    (RAD_W'({sum_ff, 32'd0})),
      .in_sb     ({ax_ff, ay_ff}),
      .out_valid (sq_v),
      .out_root  (sq_root),
      .out_sb    (sq_sb)
   );

   // normalize: round(|a| * 2^32 / r), half away from zero
   logic signed [A_W-1:0] sx_a, sy_a;
   logic [A_W-1:0]        mx_a, my_a;
   logic [N_W-1:0]        half_r;

   assign sx_a   = sq_sb[2*A_W-1:A_W];
   assign sy_a   = sq_sb[A_W-1:0];
   assign mx_a   = sx_a[A_W-1] ? A_W'(-sx_a) : A_W'(sx_a);
   assign my_a   = sy_a[A_W-1] ? A_W'(-sy_a) : A_W'(sy_a);
   assign half_r = N_W'(sq_root >> 1);

   logic             dv_x, dv_y, dv_z;
   logic [DQ_W-1:0]  qx, qy, qz;
   logic [ROOT_W-1:0] rx_unused, ry_unused, rz_unused;
   logic             sgx, sgy, sgz;

   sgbs_div_pipe #(.NUM_W(N_W), .DEN_W(ROOT_W), .Q_W(DQ_W), .SB_W(1)) u_div_x (
      .clock (clock), .reset (reset), .en (adv), .in_valid (sq_v),
      .in_num (N_W'({mx_a, 32'd0}) + half_r), .in_den (sq_root), .in_sb (sx_a[A_W-1]),
      .out_valid (dv_x), .out_q (qx), .out_rem (rx_unused), .out_sb (sgx)
   );

   sgbs_div_pipe #(.NUM_W(N_W), .DEN_W(ROOT_W), .Q_W(DQ_W), .SB_W(1)) u_div_y (
      .clock (clock), .reset (reset), .en (adv), .in_valid (sq_v),
      .in_num (N_W'({my_a, 32'd0}) + half_r), .in_den (sq_root), .in_sb (sy_a[A_W-1]),
      .out_valid (dv_y), .out_q (qy), .out_rem (ry_unused), .out_sb (sgy)
   );

   sgbs_div_pipe #(.NUM_W(N_W), .DEN_W(ROOT_W), .Q_W(DQ_W), .SB_W(1)) u_div_z (
      .clock (clock), .reset (reset), .en (adv), .in_valid (sq_v),
      .in_num (N_W'({AZ_MAG, 32'd0}) + half_r), .in_den (sq_root), .in_sb (1'b0),
      .out_valid (dv_z), .out_q (qz), .out_rem (rz_unused), .out_sb (sgz)
   );

   // stage M1: plane products and sky square
   logic signed [DQ_W:0]    dx_s, dz_s, m_s;
   logic [DQ_W-1:0]         t_sky;
   logic                    m1_v_ff, m1_hit_ff;
   logic signed [PROD_W-1:0] pxy_ff, pxm_ff, pzy_ff, pzm_ff;
   logic [2*DQ_W-1:0]       tt_ff;
   logic [DQ_W-1:0]         m_ff;

   assign dx_s  = sgx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
   assign dz_s  = sgz ? -$signed({1'b0, qz}) : $signed({1'b0, qz});
   assign m_s   = $signed({1'b0, qy});
   assign t_sky = DQ_W'((DQ_W+1)'(65536) - (DQ_W+1)'(qy));

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
      end else if (adv) begin
         m1_v_ff <= dv_x & dv_y & dv_z;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pxy_ff    <= eye_y_ff * dx_s;
         pxm_ff    <= eye_x_ff * m_s;
         pzy_ff    <= eye_y_ff * dz_s;
         pzm_ff    <= eye_z_ff * m_s;
         tt_ff     <= t_sky * t_sky;
         m_ff      <= qy;
         m1_hit_ff <= sgy;
      end
   end

   // stage M2: numerators, magnitudes, overflow test, sky gray
   logic signed [NUM_W-1:0] nx_c, nz_c;
   logic [NUM_W-1:0]        magx_c, magz_c;
   logic [DEN_W-1:0]        den_c;
   logic [42:0]             gw;
   logic [10:0]             gsh;

   assign nx_c   = NUM_W'(pxy_ff) + NUM_W'(pxm_ff);
   assign nz_c   = NUM_W'(pzy_ff) + NUM_W'(pzm_ff);
   assign magx_c = nx_c[NUM_W-1] ? NUM_W'(-nx_c) : NUM_W'(nx_c);
   assign magz_c = nz_c[NUM_W-1] ? NUM_W'(-nz_c) : NUM_W'(nz_c);
   assign den_c  = {m_ff, 8'd0};
   assign gw     = 43'({tt_ff, 8'd0}) - 43'(tt_ff) + (43'(1) << 31);
   assign gsh    = gw[42:32];

   logic                m2_v_ff;
   logic [NUM_W-1:0]    magx_ff, magz_ff;
   logic [DEN_W-1:0]    den_ff;
   logic                sx_ff, sz_ff, ovx_ff, ovz_ff, m2_hit_ff;
   logic [GRAY_W-1:0]   gsky_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_v_ff <= 1'b0;
      end else if (adv) begin
         m2_v_ff <= m1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         magx_ff   <= magx_c;
         magz_ff   <= magz_c;
         den_ff    <= den_c;
         sx_ff     <= nx_c[NUM_W-1];
         sz_ff     <= nz_c[NUM_W-1];
         ovx_ff    <= (magx_c >> DQ_W) >= NUM_W'(den_c);
         ovz_ff    <= (magz_c >> DQ_W) >= NUM_W'(den_c);
         m2_hit_ff <= m1_hit_ff;
         gsky_ff   <= (|gsh[10:8]) ? {GRAY_W{1'b1}} : gsh[7:0];
      end
   end

   // hit point floors
   logic             fv_x, fv_z;
   logic [DQ_W-1:0]  fqx, fqz;
   logic [DEN_W-1:0] frx, frz;
   logic [1:0]       fsb_x;
   logic [ZSB_W-1:0] fsb_z;

   sgbs_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(DQ_W), .SB_W(2)) u_fdiv_x (
      .clock (clock), .reset (reset), .en (adv), .in_valid (m2_v_ff),
      .in_num (magx_ff), .in_den (den_ff), .in_sb ({sx_ff, ovx_ff}),
      .out_valid (fv_x), .out_q (fqx), .out_rem (frx), .out_sb (fsb_x)
   );

   sgbs_div_pipe #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(DQ_W), .SB_W(ZSB_W)) u_fdiv_z (
      .clock (clock), .reset (reset), .en (adv), .in_valid (m2_v_ff),
      .in_num (magz_ff), .in_den (den_ff), .in_sb ({sz_ff, ovz_ff, m2_hit_ff, gsky_ff}),
      .out_valid (fv_z), .out_q (fqz), .out_rem (frz), .out_sb (fsb_z)
   );

   // output word
   logic              par_x, par_z, hit_c;
   logic [GRAY_W-1:0] gray_ff;
   logic              hit_ff;

   assign par_x = sat_parity(fqx, |frx, fsb_x[1], fsb_x[0]);
   assign par_z = sat_parity(fqz, |frz, fsb_z[ZSB_W-1], fsb_z[ZSB_W-2]);
   assign hit_c = fsb_z[GRAY_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         rsp_v_ff <= fv_x & fv_z;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff  <= hit_c;
         gray_ff <= hit_c ? ((par_x == par_z) ? '0 : {GRAY_W{1'b1}}) : fsb_z[GRAY_W-1:0];
      end
   end

   assign rsp_ch.valid      = rsp_v_ff;
   assign rsp_ch.gray_level = gray_ff;
   assign rsp_ch.hit_ground = hit_ff;

`ifndef SYNTH
   a_ground_bw: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && hit_ff |-> gray_ff == '0 || gray_ff == {GRAY_W{1'b1}})
      else $error("ground word is not black or white");

   a_root_nz: assert property (@(posedge clock) disable iff (reset)
      sq_v |-> sq_root != '0)
      else $error("zero ray length");

   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      fv_x == fv_z && dv_x == dv_y && dv_y == dv_z)
      else $error("divider lanes out of step");
`endif

endmodule

>>> src/sgbs_sqrt_pipe.sv
// Pipelined integer square root, one result bit per stage, with a sideband.
// No package dependency.
module sgbs_sqrt_pipe #(
   parameter int RAD_W = 56,
   parameter int SB_W  = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [RAD_W-1:0]    in_rad,
   input  logic [SB_W-1:0]     in_sb,
   output logic                out_valid,
   output logic [RAD_W/2-1:0]  out_root,
   output logic [SB_W-1:0]     out_sb
);
   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;

   logic [ROOT_W-1:0] v_ff;
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [SB_W-1:0]   sb_ff   [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stg
      logic              v_p;
      logic [REM_W-1:0]  rem_p;
      logic [ROOT_W-1:0] root_p;
      logic [RAD_W-1:0]  rad_p;
      logic [SB_W-1:0]   sb_p;
      logic [REM_W-1:0]  t;
      logic [REM_W-1:0]  trial;
      logic              ge;

      if (k == 0) begin : g_first
         assign v_p    = in_valid;
         assign rem_p  = '0;
         assign root_p = '0;
         assign rad_p  = in_rad;
         assign sb_p   = in_sb;
      end else begin : g_next
         assign v_p    = v_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign rad_p  = rad_ff[k-1];
         assign sb_p   = sb_ff[k-1];
      end

      assign t     = {rem_p[REM_W-3:0], rad_p[RAD_W-1 -: 2]};
      assign trial = {root_p, 2'b01};
      assign ge    = (t >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? (t - trial) : t;
            root_ff[k] <= {root_p[ROOT_W-2:0], ge};
            rad_ff[k]  <= {rad_p[RAD_W-3:0], 2'b00};
            sb_ff[k]   <= sb_p;
         end
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_sb    = sb_ff[ROOT_W-1];

endmodule

>>> src/sgbs_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
// Caller guarantees in_num >> Q_W < in_den. No package dependency.
module sgbs_div_pipe #(
   parameter int NUM_W = 44,
   parameter int DEN_W = 28,
   parameter int Q_W   = 17,
   parameter int SB_W  = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [SB_W-1:0]  in_sb,
   output logic             out_valid,
   output logic [Q_W-1:0]   out_q,
   output logic [DEN_W-1:0] out_rem,
   output logic [SB_W-1:0]  out_sb
);
   logic [Q_W-1:0]   v_ff;
   logic [DEN_W-1:0] rem_ff [Q_W];
   logic [DEN_W-1:0] den_ff [Q_W];
   logic [Q_W-1:0]   q_ff   [Q_W];
   logic [Q_W-1:0]   lo_ff  [Q_W];
   logic [SB_W-1:0]  sb_ff  [Q_W];

   for (genvar k = 0; k < Q_W; k++) begin : g_stg
      logic             v_p;
      logic [DEN_W-1:0] rem_p;
      logic [DEN_W-1:0] den_p;
      logic [Q_W-1:0]   q_p;
      logic [Q_W-1:0]   lo_p;
      logic [SB_W-1:0]  sb_p;
      logic [DEN_W:0]   t;
      logic [DEN_W:0]   dif;
      logic             ge;

      if (k == 0) begin : g_first
         assign v_p   = in_valid;
         assign rem_p = DEN_W'(in_num >> Q_W);
         assign den_p = in_den;
         assign q_p   = '0;
         assign lo_p  = in_num[Q_W-1:0];
         assign sb_p  = in_sb;
      end else begin : g_next
         assign v_p   = v_ff[k-1];
         assign rem_p = rem_ff[k-1];
         assign den_p = den_ff[k-1];
         assign q_p   = q_ff[k-1];
         assign lo_p  = lo_ff[k-1];
         assign sb_p  = sb_ff[k-1];
      end

      assign t   = {rem_p, lo_p[Q_W-1]};
      assign ge  = (t >= {1'b0, den_p});
      assign dif = t - {1'b0, den_p};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= ge ? dif[DEN_W-1:0] : t[DEN_W-1:0];
            den_ff[k] <= den_p;
            q_ff[k]   <= {q_p[Q_W-2:0], ge};
            lo_ff[k]  <= {lo_p[Q_W-2:0], 1'b0};
            sb_ff[k]  <= sb_p;
         end
      end
   end

   assign out_valid = v_ff[Q_W-1];
   assign out_q     = q_ff[Q_W-1];
   assign out_rem   = rem_ff[Q_W-1];
   assign out_sb    = sb_ff[Q_W-1];

endmodule
